// ----- design/tce_pkg.sv -----
// ----------------------------------------------------------------------------
// Clause evaluator package
// Operation codes, configuration register indexes and field widths shared by
// the clause evaluator.
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int unsigned OpW       = 2;
  localparam int unsigned FeatIdxW  = 10;
  localparam int unsigned StateW    = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [OpW-1:0] {
    OpWrite   = 2'd0,
    OpLiteral = 2'd1,
    OpEnd     = 2'd2
  } op_e;

  localparam logic [CfgIdxW-1:0] CfgInferenceMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStateCount    = 2'd1;

  localparam logic [StateW-1:0] StateCountRst = 16'd256;

endpackage

// ----- design/tsetlin_clause_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// Tsetlin clause evaluator
// Holds a binary feature vector in a single-bit memory and evaluates one
// clause over it, one literal per beat, emitting the clause output on an end
// beat.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle of any kind (feature write, literal or
// end of clause) while in_stall_o is low, and emits one result beat per end
// beat; a result is ready in the cycle after its end beat. A literal reads the
// feature memory at the edge it is accepted and folds into the running AND in
// the cycle after; an end beat that follows directly takes that pending
// literal into account, so back-to-back beats never wait. After reset the
// feature memory is swept to zero, one entry per cycle, with in_stall_o high
// until the sweep is done, while configuration writes are taken as usual.
// Configuration is meant to change only while no clause is in flight.
module tsetlin_clause_evaluator_top #(
  parameter int unsigned MAX_FEATURES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tce_pkg::OpW-1:0]       operation_i,
  input  logic [tce_pkg::FeatIdxW-1:0]  feature_index_i,
  input  logic                          feature_bit_i,
  input  logic                          negated_i,
  input  logic [tce_pkg::StateW-1:0]    automaton_state_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          clause_output_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tce_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tce_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned AddrW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned AddrExtW = (AddrW > tce_pkg::FeatIdxW) ? AddrW : tce_pkg::FeatIdxW;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_FEATURES - 1);

  // configuration
  logic                        inf_mode_q;
  logic [tce_pkg::StateW-1:0]  state_cnt_q;

  // clear sweep
  logic                        clr_busy_q;
  logic [AddrW-1:0]            clr_addr_q;

  // feature memory
  logic                        mem_q [MAX_FEATURES];
  logic                        mem_we;
  logic [AddrW-1:0]            mem_waddr;
  logic                        mem_wdata;
  logic                        mem_re;
  logic                        rdata_q;

  // literal stage
  logic                        lit_vld_q;
  logic                        lit_inc_q;
  logic                        lit_neg_q;
  logic                        lit_rng_q;
  logic                        lit_feat;
  logic                        lit_fail;

  // clause state and result
  logic                        alive_q, alive_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_q, out_d;

  logic                        in_acc;
  tce_pkg::op_e                op;
  logic [AddrExtW-1:0]         idx_ext;
  logic [AddrW-1:0]            idx_addr;
  logic                        idx_in_range;
  logic                        included;
  logic                        is_write;
  logic                        is_literal;
  logic                        is_end;

  assign in_stall_o  = clr_busy_q | (out_valid_q & out_stall_i);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign op           = tce_pkg::op_e'(operation_i);
  assign idx_ext      = AddrExtW'(feature_index_i);
  assign idx_addr     = idx_ext[AddrW-1:0];
  assign idx_in_range = 32'(feature_index_i) < 32'(MAX_FEATURES);
  assign included     = inf_mode_q | (automaton_state_i > (state_cnt_q >> 1));

  always_comb begin
    is_write   = 1'b0;
    is_literal = 1'b0;
    is_end     = 1'b0;
    unique case (op)
      tce_pkg::OpWrite:   is_write   = 1'b1;
      tce_pkg::OpLiteral: is_literal = 1'b1;
      tce_pkg::OpEnd:     is_end     = 1'b1;
      default: ;  // unused code: drop the beat
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inf_mode_q  <= 1'b0;
      state_cnt_q <= tce_pkg::StateCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tce_pkg::CfgInferenceMode: inf_mode_q  <= cfg_data_i[0];
        tce_pkg::CfgStateCount:    state_cnt_q <= cfg_data_i[tce_pkg::StateW-1:0];
        default: ;
      endcase
    end
  end

  // zero sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == LastAddr) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign mem_we    = clr_busy_q | (in_acc & is_write & idx_in_range);
  assign mem_waddr = clr_busy_q ? clr_addr_q : idx_addr;
  assign mem_wdata = clr_busy_q ? 1'b0 : feature_bit_i;
  assign mem_re    = in_acc & is_literal & idx_in_range;

  // writes land at accept, so a later literal always sees them
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[idx_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_vld_q <= 1'b0;
    end else begin
      lit_vld_q <= in_acc & is_literal;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_literal) begin
      lit_inc_q <= included;
      lit_neg_q <= negated_i;
      lit_rng_q <= idx_in_range;
    end
  end

  // out-of-range features read as zero
  assign lit_feat = lit_rng_q & rdata_q;
  assign lit_fail = lit_vld_q & lit_inc_q & (lit_neg_q ? lit_feat : ~lit_feat);

  always_comb begin
    alive_d     = alive_q & ~lit_fail;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    if (in_acc && is_end) begin
      // fold in the pending literal, then rearm
      out_valid_d = 1'b1;
      out_d       = alive_q & ~lit_fail;
      alive_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      alive_q     <= alive_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign clause_output_o = out_q;

  // --------------------------------------------------------------------------
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_end) |=> out_valid_q)
    else $error("end beat produced no result");

  a_sweep_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_busy_q |=> !clr_busy_q)
    else $error("clear sweep restarted");

  a_no_result_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !out_valid_q)
    else $error("result while sweeping the feature memory");

  a_lit_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_vld_q |-> $past(in_acc && is_literal))
    else $error("pending literal without an accepted literal beat");

endmodule

// ----- tb/sv/tsetlin_clause_evaluator_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clause evaluator testbench
// Drives feature writes, literals and end-of-clause beats into the clause
// evaluator. The scoreboard mirrors the feature vector, the running AND and
// the two configuration registers, and checks every clause output in order.
// The run covers a directed opening and several random phases, each with its
// own register settings and one of four mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tsetlin_clause_evaluator_top_tb;

  localparam int unsigned NumFeatures           = 1024;
  localparam logic [tce_pkg::OpW-1:0] OpUnused  = 2'd3;
  localparam int unsigned ItemsPerPhase         = 125;
  localparam int unsigned NumPhases             = 8;
  localparam int unsigned DrainCycles           = 8;

  class clause_scoreboard;
    bit                         features [NumFeatures];
    bit                         clause_ok;
    bit                         infer_mode;
    logic [tce_pkg::StateW-1:0] num_states;
    bit                         clause_q [$];
    int unsigned                errors;
    int unsigned                beats_seen;
    int unsigned                true_seen;
    int unsigned                false_seen;

    function new();
      foreach (features[i]) features[i] = 1'b0;
      clause_ok  = 1'b1;
      infer_mode = 1'b0;
      num_states = tce_pkg::StateCountRst;
      errors     = 0;
      beats_seen = 0;
      true_seen  = 0;
      false_seen = 0;
    endfunction

    function void note_config(logic [tce_pkg::CfgIdxW-1:0] idx,
                              logic [tce_pkg::CfgDataW-1:0] data);
      if (idx == tce_pkg::CfgInferenceMode) infer_mode = data[0];
      else if (idx == tce_pkg::CfgStateCount) num_states = data[tce_pkg::StateW-1:0];
    endfunction

    function void note_beat(logic [tce_pkg::OpW-1:0] op,
                            logic [tce_pkg::FeatIdxW-1:0] idx, logic fbit,
                            logic neg, logic [tce_pkg::StateW-1:0] st);
      bit included;
      bit feat;
      beats_seen++;
      case (op)
        tce_pkg::OpWrite: begin
          features[idx] = fbit;
        end
        tce_pkg::OpLiteral: begin
          included = infer_mode || (st > (num_states >> 1));
          feat     = features[idx];
          if (included && (neg ? feat : !feat)) clause_ok = 1'b0;
        end
        tce_pkg::OpEnd: begin
          clause_q.push_back(clause_ok);
          clause_ok = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic actual);
      bit want;
      if (clause_q.size() == 0) begin
        $error("clause_output: no result expected, actual %0d", actual);
        errors++;
      end else begin
        want = clause_q.pop_front();
        if (actual !== want) begin
          $error("clause_output: expected %0d, actual %0d", want, actual);
          errors++;
        end
        if (want) true_seen++;
        else false_seen++;
      end
    endfunction

    function int unsigned pending();
      return clause_q.size();
    endfunction
  endclass

  logic                                 clk_i             = 1'b0;
  logic                                 rst_ni            = 1'b0;
  logic                                 in_valid_i        = 1'b0;
  logic                                 in_stall_o;
  logic [tce_pkg::OpW-1:0]              operation_i       = '0;
  logic [tce_pkg::FeatIdxW-1:0]         feature_index_i   = '0;
  logic                                 feature_bit_i     = 1'b0;
  logic                                 negated_i         = 1'b0;
  logic [tce_pkg::StateW-1:0]           automaton_state_i = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i       = 1'b0;
  logic                                 clause_output_o;
  logic                                 cfg_valid_i       = 1'b0;
  logic                                 cfg_ready_o;
  logic [tce_pkg::CfgIdxW-1:0]          cfg_index_i       = '0;
  logic [tce_pkg::CfgDataW-1:0]         cfg_data_i        = '0;

  clause_scoreboard sb = new();

  int unsigned                in_idle_pct   = 0;
  int unsigned                out_stall_pct = 0;
  bit                         feat_shadow [NumFeatures];
  logic [tce_pkg::StateW-1:0] cur_states    = tce_pkg::StateCountRst;

  tsetlin_clause_evaluator_top #(
    .MAX_FEATURES(NumFeatures)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .feature_index_i  (feature_index_i),
    .feature_bit_i    (feature_bit_i),
    .negated_i        (negated_i),
    .automaton_state_i(automaton_state_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .clause_output_o  (clause_output_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(clause_output_o);
      if (in_valid_i && !in_stall_o) begin
        sb.note_beat(operation_i, feature_index_i, feature_bit_i, negated_i,
                     automaton_state_i);
      end
      if (cfg_valid_i && cfg_ready_o) sb.note_config(cfg_index_i, cfg_data_i);
    end
  end

  // Leave valid high on return so the next beat can follow without a gap.
  task automatic send_beat(input logic [tce_pkg::OpW-1:0] op,
                           input logic [tce_pkg::FeatIdxW-1:0] idx,
                           input logic fbit, input logic neg,
                           input logic [tce_pkg::StateW-1:0] st);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    operation_i       <= op;
    feature_index_i   <= idx;
    feature_bit_i     <= fbit;
    negated_i         <= neg;
    automaton_state_i <= st;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op == tce_pkg::OpWrite) feat_shadow[idx] = fbit;
  endtask

  task automatic write_reg(input logic [tce_pkg::CfgIdxW-1:0] idx,
                           input logic [tce_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic configure(input bit infer, input logic [tce_pkg::StateW-1:0] states);
    write_reg(tce_pkg::CfgInferenceMode, tce_pkg::CfgDataW'(infer));
    write_reg(tce_pkg::CfgStateCount, tce_pkg::CfgDataW'(states));
    cfg_valid_i <= 1'b0;
    cur_states = states;
  endtask

  // Hold off until every clause result is back and the pipeline has settled.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly a small window of features so writes and literals collide.
  function automatic logic [tce_pkg::FeatIdxW-1:0] pick_index();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return tce_pkg::FeatIdxW'($urandom_range(0, 15));
    if (r == 6) return '1;
    return tce_pkg::FeatIdxW'($urandom);
  endfunction

  function automatic logic [tce_pkg::StateW-1:0] pick_state();
    case ($urandom_range(0, 3))
      0, 1:    return tce_pkg::StateW'($urandom);
      2:       return (cur_states >> 1) + tce_pkg::StateW'($urandom_range(0, 1));
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  task automatic random_clauses(input int unsigned target);
    int unsigned                  counted;
    logic [tce_pkg::FeatIdxW-1:0] idx;
    logic                         neg;
    counted = 0;
    while (counted < target) begin
      if ($urandom_range(0, 99) < 4) begin
        send_beat(OpUnused, tce_pkg::FeatIdxW'($urandom), 1'($urandom), 1'($urandom),
                  tce_pkg::StateW'($urandom));
      end else begin
        repeat ($urandom_range(0, 2)) begin
          send_beat(tce_pkg::OpWrite, pick_index(), 1'($urandom), 1'($urandom),
                    tce_pkg::StateW'($urandom));
          counted++;
        end
        repeat ($urandom_range(0, 6)) begin
          idx = pick_index();
          // satisfy most literals so clauses survive often enough
          neg = ($urandom_range(0, 3) == 0) ? feat_shadow[idx] : !feat_shadow[idx];
          send_beat(tce_pkg::OpLiteral, idx, 1'($urandom), neg, pick_state());
          counted++;
        end
        send_beat(tce_pkg::OpEnd, tce_pkg::FeatIdxW'($urandom), 1'($urandom),
                  1'($urandom), tce_pkg::StateW'($urandom));
        counted++;
      end
    end
  endtask

  initial begin
    foreach (feat_shadow[i]) feat_shadow[i] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    configure(1'b0, tce_pkg::StateCountRst);

    // directed: extremes, threshold, empty clause, unused code, unwritten feature
    send_beat(tce_pkg::OpWrite,   '0,      1'b1, 1'b0, '0);
    send_beat(tce_pkg::OpWrite,   '1,      1'b1, 1'b1, '1);
    send_beat(tce_pkg::OpWrite,   10'd5,   1'b0, 1'b0, '0);
    send_beat(tce_pkg::OpLiteral, '0,      1'b0, 1'b0, '1);
    send_beat(tce_pkg::OpEnd,     '0,      1'b0, 1'b0, '0);
    send_beat(tce_pkg::OpLiteral, '1,      1'b0, 1'b1, 16'd129);
    send_beat(tce_pkg::OpEnd,     '1,      1'b1, 1'b1, '1);
    send_beat(tce_pkg::OpLiteral, 10'd5,   1'b0, 1'b0, 16'd128);
    send_beat(tce_pkg::OpEnd,     '0,      1'b0, 1'b0, '0);
    send_beat(tce_pkg::OpEnd,     '0,      1'b0, 1'b0, '0);
    send_beat(OpUnused,           '1,      1'b1, 1'b1, '1);
    send_beat(tce_pkg::OpLiteral, 10'd5,   1'b1, 1'b1, '0);
    send_beat(tce_pkg::OpLiteral, '0,      1'b0, 1'b1, '1);
    send_beat(tce_pkg::OpEnd,     '0,      1'b0, 1'b0, '0);
    send_beat(tce_pkg::OpWrite,   '1,      1'b0, 1'b0, '0);
    send_beat(tce_pkg::OpLiteral, '1,      1'b0, 1'b0, 16'd200);
    send_beat(tce_pkg::OpEnd,     '0,      1'b0, 1'b0, '0);
    send_beat(tce_pkg::OpLiteral, 10'd700, 1'b0, 1'b1, '1);
    send_beat(tce_pkg::OpEnd,     '0,      1'b0, 1'b0, '0);
    send_beat(tce_pkg::OpLiteral, 10'd700, 1'b0, 1'b0, '1);
    send_beat(tce_pkg::OpEnd,     '0,      1'b0, 1'b0, '0);
    drain();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1:       begin in_idle_pct = 69; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 69; end
        default: begin in_idle_pct = 27; out_stall_pct = 27; end
      endcase
      case (p)
        0:       configure(1'b0, tce_pkg::StateCountRst);
        1:       configure(1'b1, tce_pkg::StateCountRst);
        2:       configure(1'b0, 16'd1);
        3:       configure(1'b0, 16'hFFFF);
        4:       configure(1'b0, 16'd0);
        5:       configure(1'b1, tce_pkg::StateW'($urandom));
        default: configure(1'b0, tce_pkg::StateW'($urandom));
      endcase
      random_clauses(ItemsPerPhase);
      drain();
    end

    out_stall_pct = 0;
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending() != 0) $error("clause_output: %0d results never arrived", sb.pending());
    $display("summary: %0d input beats over %0d register settings and four idle mixes",
             sb.beats_seen, NumPhases + 1);
    $display("summary: %0d clause results checked, %0d true and %0d false",
             sb.true_seen + sb.false_seen, sb.true_seen, sb.false_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- tsetlin_clause_evaluator_top.f -----
design/tce_pkg.sv
design/tsetlin_clause_evaluator_top.sv
tb/sv/tsetlin_clause_evaluator_top_tb.sv
